/* design/gng_pkg.sv */
// shared types, constants and elaboration-time helpers for the gaussian noise generator
package gng_pkg;

    localparam int MUL_W = 34;

    localparam logic [30:0] GEN_MOD   = 31'h7FFF_FFFF;
    localparam logic [30:0] SEED_MASK = 31'd123459876;
    localparam logic [33:0] GEN_MUL   = 34'd16807;
    localparam logic [33:0] LN2Q30    = 34'h2C5C85FE;

    localparam logic [33:0] ONE24 = 34'd16777216;
    localparam logic [33:0] C0 = 34'(((64'd2515517 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [33:0] C1 = 34'(((64'd802853 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [33:0] C2 = 34'(((64'd10328 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [33:0] D1 = 34'(((64'd1432788 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [33:0] D2 = 34'(((64'd189269 << 24) + 64'd500000) / 64'd1000000);
    localparam logic [33:0] D3 = 34'(((64'd1308 << 24) + 64'd500000) / 64'd1000000);

    // log2 in Q28, evaluated at elaboration only
    function automatic logic [33:0] log2_q28(input logic [63:0] a);
        logic [5:0]   e;
        logic [63:0]  m;
        logic [127:0] sq;
        logic [27:0]  frac;
        e    = '0;
        frac = '0;
        for (int i = 1; i < 64; i++)
        begin
            if ((a >> i) != 64'd0)
            begin
                e = 6'(i);
            end
        end
        if (e <= 6'd31)
        begin
            m = a << (6'd31 - e);
        end
        else
        begin
            m = a >> (e - 6'd31);
        end
        for (int i = 0; i < 28; i++)
        begin
            sq   = 128'(m) * 128'(m);
            m    = sq[94:31];
            frac = {frac[26:0], 1'b0};
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {e, frac};
    endfunction

    localparam logic [33:0] LOG2_MOD = log2_q28(64'd2147483647);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MOD_I,
        ST_MOD_W,
        ST_NORM,
        ST_LOG_I,
        ST_LOG_W,
        ST_L,
        ST_T2_I,
        ST_T2_W,
        ST_SQRT,
        ST_PROD_I,
        ST_PROD_W,
        ST_DIV_INIT,
        ST_DIV,
        ST_MAG,
        ST_SC_I,
        ST_SC_W,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PS_TT,
        PS_TTT,
        PS_N1,
        PS_N2,
        PS_D1,
        PS_D2,
        PS_D3
    } prod_step_t;

    typedef struct packed {
        logic        start;
        logic [15:0] sigma;
        logic [30:0] value;
    } core_req_t;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [23:0] sample;
        logic [30:0] value;
        logic        stuck;
    } core_rsp_t;

endpackage

/* design/gng_mul.sv */
// shared unsigned multiplier with registered product
module gng_mul
(
    input  logic                              clk,
    input  logic [gng_pkg::MUL_W-1:0]         a,
    input  logic [gng_pkg::MUL_W-1:0]         b,
    output logic [2*gng_pkg::MUL_W-1:0]       p
);

    logic [2*gng_pkg::MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= (2*gng_pkg::MUL_W)'(a) * (2*gng_pkg::MUL_W)'(b);
    end

    assign p = p_reg;

endmodule

/* design/gng_core.sv */
// sequencer and datapath: generator step, log2, sqrt, rational divide, scaling
module gng_core
#(
    parameter int OUT_FRAC_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gng_pkg::core_req_t req,
    input  logic               ack,
    output gng_pkg::core_rsp_t rsp
);

    localparam int SH = 32 - OUT_FRAC_BITS;
    localparam int PW = 2 * gng_pkg::MUL_W;

    gng_pkg::state_t     state_reg, state_next;
    gng_pkg::prod_step_t step_reg;

    logic [15:0] sigma_reg;
    logic [30:0] v_reg;
    logic        stuck_reg;
    logic        lower_reg;
    logic [29:0] x_reg;
    logic [4:0]  e_reg;
    logic [31:0] m_reg;
    logic [27:0] frac_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] l_reg;
    logic [53:0] sa_reg, sr_reg, sb_reg;
    logic [26:0] t_reg;
    logic [29:0] tt_reg;
    logic [32:0] ttt_reg;
    logic [28:0] num_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_reg;
    logic [29:0] dd_reg;
    logic [29:0] q_reg;
    logic        neg_reg;
    logic [29:0] mag_reg;
    logic [23:0] sample_reg;

    logic [gng_pkg::MUL_W-1:0] mul_a, mul_b;
    logic [PW-1:0]             prod;

    gng_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // modular fold of v * 16807 over 2^31-1
    logic [31:0] fold_s;
    logic [30:0] fold_v, fold_c;
    assign fold_s = 32'(prod[30:0]) + 32'(prod[45:31]);
    assign fold_v = (fold_s >= 32'(gng_pkg::GEN_MOD)) ? 31'(fold_s - 32'(gng_pkg::GEN_MOD))
                                                      : fold_s[30:0];
    assign fold_c = gng_pkg::GEN_MOD - fold_v;

    logic [32:0] sq;
    assign sq = prod[63:31];

    logic [PW-1:0] t2_rnd;
    assign t2_rnd = prod + (PW'(1) << 24);

    // square root, one result bit per cycle
    logic [53:0] s_try, sa_new, sr_new;
    always_comb
    begin
        s_try = sr_reg + sb_reg;
        if (sa_reg >= s_try)
        begin
            sa_new = sa_reg - s_try;
            sr_new = (sr_reg >> 1) + sb_reg;
        end
        else
        begin
            sa_new = sa_reg;
            sr_new = sr_reg >> 1;
        end
    end

    logic [PW-1:0] r24_rnd;
    logic [43:0]   r24;
    assign r24_rnd = prod + (PW'(1) << 23);
    assign r24     = r24_rnd[67:24];

    // restoring divide, one quotient bit per cycle
    logic [53:0] dvd;
    logic [32:0] rs;
    logic        qbit;
    logic [32:0] rem_new;
    assign dvd = 54'({num_reg, 24'd0}) + 54'(den_reg[31:1]);
    always_comb
    begin
        rs = {rem_reg[31:0], dd_reg[29]};
        if (rs >= 33'(den_reg))
        begin
            qbit    = 1'b1;
            rem_new = rs - 33'(den_reg);
        end
        else
        begin
            qbit    = 1'b0;
            rem_new = rs;
        end
    end

    logic [29:0] tz;
    assign tz = 30'(t_reg);

    logic [PW-1:0] sc_rnd, sc_sh;
    logic [34:0]   sc_mag;
    logic [23:0]   sc_sample;
    assign sc_rnd = prod + (PW'(1) << (SH - 1));
    assign sc_sh  = sc_rnd >> SH;
    assign sc_mag = sc_sh[34:0];
    always_comb
    begin
        if (neg_reg)
        begin
            if (sc_mag > 35'h80_0000)
            begin
                sc_sample = 24'h80_0000;
            end
            else
            begin
                sc_sample = 24'(35'd0 - sc_mag);
            end
        end
        else if (sc_mag > 35'h7F_FFFF)
        begin
            sc_sample = 24'h7F_FFFF;
        end
        else
        begin
            sc_sample = sc_mag[23:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gng_pkg::ST_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.sigma == 16'd0) ? gng_pkg::ST_DONE : gng_pkg::ST_MOD_I;
                end
            end
            gng_pkg::ST_MOD_I:    state_next = gng_pkg::ST_MOD_W;
            gng_pkg::ST_MOD_W:    state_next = stuck_reg ? gng_pkg::ST_DONE : gng_pkg::ST_NORM;
            gng_pkg::ST_NORM:
            begin
                if (x_reg[29])
                begin
                    state_next = gng_pkg::ST_LOG_I;
                end
            end
            gng_pkg::ST_LOG_I:    state_next = gng_pkg::ST_LOG_W;
            gng_pkg::ST_LOG_W:
            begin
                state_next = (cnt_reg == 5'd27) ? gng_pkg::ST_L : gng_pkg::ST_LOG_I;
            end
            gng_pkg::ST_L:        state_next = gng_pkg::ST_T2_I;
            gng_pkg::ST_T2_I:     state_next = gng_pkg::ST_T2_W;
            gng_pkg::ST_T2_W:     state_next = gng_pkg::ST_SQRT;
            gng_pkg::ST_SQRT:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gng_pkg::ST_PROD_I;
                end
            end
            gng_pkg::ST_PROD_I:   state_next = gng_pkg::ST_PROD_W;
            gng_pkg::ST_PROD_W:
            begin
                state_next = (step_reg == gng_pkg::PS_D3) ? gng_pkg::ST_DIV_INIT
                                                          : gng_pkg::ST_PROD_I;
            end
            gng_pkg::ST_DIV_INIT: state_next = gng_pkg::ST_DIV;
            gng_pkg::ST_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gng_pkg::ST_MAG;
                end
            end
            gng_pkg::ST_MAG:      state_next = gng_pkg::ST_SC_I;
            gng_pkg::ST_SC_I:     state_next = gng_pkg::ST_SC_W;
            gng_pkg::ST_SC_W:     state_next = gng_pkg::ST_DONE;
            gng_pkg::ST_DONE:
            begin
                if (ack)
                begin
                    state_next = gng_pkg::ST_IDLE;
                end
            end
            default:              state_next = gng_pkg::ST_IDLE;
        endcase
    end

    // outputs: multiplier operands and status
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gng_pkg::ST_MOD_I:
            begin
                mul_a = 34'(v_reg);
                mul_b = gng_pkg::GEN_MUL;
            end
            gng_pkg::ST_LOG_I:
            begin
                mul_a = 34'(m_reg);
                mul_b = 34'(m_reg);
            end
            gng_pkg::ST_T2_I:
            begin
                mul_a = l_reg;
                mul_b = gng_pkg::LN2Q30;
            end
            gng_pkg::ST_PROD_I:
            begin
                case (step_reg)
                    gng_pkg::PS_TT:
                    begin
                        mul_a = 34'(t_reg);
                        mul_b = 34'(t_reg);
                    end
                    gng_pkg::PS_TTT:
                    begin
                        mul_a = 34'(tt_reg);
                        mul_b = 34'(t_reg);
                    end
                    gng_pkg::PS_N1:
                    begin
                        mul_a = gng_pkg::C1;
                        mul_b = 34'(t_reg);
                    end
                    gng_pkg::PS_N2:
                    begin
                        mul_a = gng_pkg::C2;
                        mul_b = 34'(tt_reg);
                    end
                    gng_pkg::PS_D1:
                    begin
                        mul_a = gng_pkg::D1;
                        mul_b = 34'(t_reg);
                    end
                    gng_pkg::PS_D2:
                    begin
                        mul_a = gng_pkg::D2;
                        mul_b = 34'(tt_reg);
                    end
                    gng_pkg::PS_D3:
                    begin
                        mul_a = gng_pkg::D3;
                        mul_b = 34'(ttt_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            gng_pkg::ST_SC_I:
            begin
                mul_a = 34'(mag_reg);
                mul_b = 34'(sigma_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp.idle   = (state_reg == gng_pkg::ST_IDLE);
        rsp.done   = (state_reg == gng_pkg::ST_DONE);
        rsp.sample = sample_reg;
        rsp.value  = v_reg;
        rsp.stuck  = stuck_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gng_pkg::ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= gng_pkg::PS_TT;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                gng_pkg::ST_LOG_I:    cnt_reg <= cnt_reg;
                gng_pkg::ST_NORM:     cnt_reg <= '0;
                gng_pkg::ST_LOG_W:    cnt_reg <= cnt_reg + 5'd1;
                gng_pkg::ST_T2_W:     cnt_reg <= 5'd26;
                gng_pkg::ST_SQRT:     cnt_reg <= cnt_reg - 5'd1;
                gng_pkg::ST_DIV_INIT: cnt_reg <= 5'd29;
                gng_pkg::ST_DIV:      cnt_reg <= cnt_reg - 5'd1;
                default:              cnt_reg <= cnt_reg;
            endcase
            case (state_reg)
                gng_pkg::ST_SQRT:     step_reg <= gng_pkg::PS_TT;
                gng_pkg::ST_PROD_W:
                begin
                    if (step_reg != gng_pkg::PS_D3)
                    begin
                        step_reg <= gng_pkg::prod_step_t'(step_reg + 3'd1);
                    end
                end
                default:              step_reg <= step_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gng_pkg::ST_IDLE:
            begin
                if (req.start)
                begin
                    sigma_reg  <= req.sigma;
                    v_reg      <= req.value;
                    stuck_reg  <= (req.value == 31'd0) || (req.value == gng_pkg::GEN_MOD);
                    sample_reg <= '0;
                end
            end
            gng_pkg::ST_MOD_W:
            begin
                v_reg     <= fold_v;
                lower_reg <= (fold_v < fold_c);
                x_reg     <= (fold_v < fold_c) ? fold_v[29:0] : fold_c[29:0];
                e_reg     <= 5'd29;
                frac_reg  <= '0;
            end
            gng_pkg::ST_NORM:
            begin
                if (x_reg[29])
                begin
                    m_reg <= {x_reg, 2'b00};
                end
                else
                begin
                    x_reg <= {x_reg[28:0], 1'b0};
                    e_reg <= e_reg - 5'd1;
                end
            end
            gng_pkg::ST_LOG_W:
            begin
                if (sq[32])
                begin
                    m_reg    <= sq[32:1];
                    frac_reg <= {frac_reg[26:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq[31:0];
                    frac_reg <= {frac_reg[26:0], 1'b0};
                end
            end
            gng_pkg::ST_L:
            begin
                l_reg <= gng_pkg::LOG2_MOD - 34'({e_reg, frac_reg});
            end
            gng_pkg::ST_T2_W:
            begin
                sa_reg <= {t2_rnd[62:25], 16'd0};
                sr_reg <= '0;
                sb_reg <= 54'(1) << 52;
            end
            gng_pkg::ST_SQRT:
            begin
                sa_reg <= sa_new;
                sr_reg <= sr_new;
                sb_reg <= sb_reg >> 2;
                t_reg  <= sr_new[26:0];
            end
            gng_pkg::ST_PROD_W:
            begin
                case (step_reg)
                    gng_pkg::PS_TT:  tt_reg  <= r24[29:0];
                    gng_pkg::PS_TTT: ttt_reg <= r24[32:0];
                    gng_pkg::PS_N1:  num_reg <= 29'(44'(gng_pkg::C0) + r24);
                    gng_pkg::PS_N2:  num_reg <= 29'(44'(num_reg) + r24);
                    gng_pkg::PS_D1:  den_reg <= 32'(44'(gng_pkg::ONE24) + r24);
                    gng_pkg::PS_D2:  den_reg <= 32'(44'(den_reg) + r24);
                    gng_pkg::PS_D3:  den_reg <= 32'(44'(den_reg) + r24);
                    default:         den_reg <= den_reg;
                endcase
            end
            gng_pkg::ST_DIV_INIT:
            begin
                rem_reg <= 33'(dvd[53:30]);
                dd_reg  <= dvd[29:0];
                q_reg   <= '0;
            end
            gng_pkg::ST_DIV:
            begin
                rem_reg <= rem_new;
                dd_reg  <= {dd_reg[28:0], 1'b0};
                q_reg   <= {q_reg[28:0], qbit};
            end
            gng_pkg::ST_MAG:
            begin
                if (tz >= q_reg)
                begin
                    mag_reg <= tz - q_reg;
                    neg_reg <= lower_reg;
                end
                else
                begin
                    mag_reg <= q_reg - tz;
                    neg_reg <= !lower_reg;
                end
            end
            gng_pkg::ST_SC_W:
            begin
                sample_reg <= sc_sample;
            end
            default:
            begin
                sample_reg <= sample_reg;
            end
        endcase
    end

endmodule

/* design/gaussian_noise_generator.sv */
// top level: request and result channels, seed register port, generator state
// Gaussian noise generator. Each request beat carries sigma (unsigned Q8.8); the
// block steps a minimal-standard multiplicative generator (16807 mod 2^31-1),
// folds u into its lower half, forms t = sqrt(-2 ln p) and applies the rational
// tail approximation, then scales by sigma into a signed sample with
// OUT_FRAC_BITS fraction bits, saturated to 24 bits. Every result beat also
// carries the new generator value, the software-visible seed (value xor mask)
// and a stuck flag. Sigma of zero returns zero without advancing the state.
// Otherwise requests are handled one at a time; the bulk of the work is the 28
// log2 squarings on the shared 34x34 multiplier, the normalize shift (one bit a
// cycle), the 27-step square root and the 30-step restoring divide. A stuck
// state (0 or 2^31-1) finishes after the generator step with status set and
// sample 0. The start_seed register sits at byte address 0; reads return the
// current seed. The request side is not ready while an item is in flight; a
// finished result is held in the output register until taken.
module gaussian_noise_generator
#(
    parameter int OUT_FRAC_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        sigma,
    input  logic               req_valid,
    output logic               req_ready,
    output logic signed [23:0] sample,
    output logic [30:0]        uniform,
    output logic [30:0]        seed_out,
    output logic               status,
    output logic               res_valid,
    input  logic               res_ready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // register index taken from the word address bit
    localparam logic REG_START_SEED = 1'b0;

    logic [30:0] value_reg;
    logic        res_valid_reg;
    logic [23:0] sample_reg;
    logic [30:0] uniform_reg;
    logic        status_reg;

    gng_pkg::core_req_t req;
    gng_pkg::core_rsp_t rsp;
    logic               ack;
    logic               cfg_wr;

    assign req_ready = rsp.idle;
    assign req.start = req_valid && rsp.idle;
    assign req.sigma = sigma;
    assign req.value = value_reg;

    // result moves to the output register when it is empty or being drained
    assign ack = rsp.done && (!res_valid_reg || res_ready);

    gng_core #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ack   (ack),
        .rsp   (rsp)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_START_SEED) ? {1'b0, value_reg ^ gng_pkg::SEED_MASK}
                                                 : 32'd0;

    // generator state: a seed write takes priority over the step result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= 31'd1 ^ gng_pkg::SEED_MASK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_START_SEED))
            begin
                value_reg <= pwdata[30:0] ^ gng_pkg::SEED_MASK;
            end
            else if (ack)
            begin
                value_reg <= rsp.value;
            end
            if (ack)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            sample_reg  <= rsp.sample;
            uniform_reg <= rsp.value;
            status_reg  <= rsp.stuck;
        end
    end

    assign res_valid = res_valid_reg;
    assign sample    = sample_reg;
    assign uniform   = uniform_reg;
    assign seed_out  = uniform_reg ^ gng_pkg::SEED_MASK;
    assign status    = status_reg;

endmodule

/* bench/gaussian_noise_generator_tb.sv */
// self-checking bench for the gaussian noise generator: directed table, random draws, seed writes
module gaussian_noise_generator_tb;

    localparam int FRAC_BITS = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 700;

    typedef struct {
        logic signed [23:0] sample;
        logic [30:0]        uniform;
        logic [30:0]        seed_out;
        logic               status;
        bit                 fixed;      // sample and status typed in by hand
        logic signed [23:0] fix_sample;
        logic               fix_status;
    } draw_t;

    typedef enum bit {ROW_SEED, ROW_DRAW} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [30:0]        value;      // seed for ROW_SEED, sigma for ROW_DRAW
        bit                 fixed;
        logic signed [23:0] fix_sample;
        logic               fix_status;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic [15:0]        sigma;
    logic               req_valid;
    logic               req_ready;
    logic signed [23:0] sample;
    logic [30:0]        uniform;
    logic [30:0]        seed_out;
    logic               status;
    logic               res_valid;
    logic               res_ready;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state and pending draws
    logic [30:0] gen_state;
    draw_t       pending_draws[$];
    int          fail_count;
    int          beats_out;
    bit          idling_on;
    bit          held_long;
    int          quiet_cycles;
    bit          fix_pending;
    logic signed [23:0] fix_sample_next;
    logic        fix_status_next;

    gaussian_noise_generator #(.OUT_FRAC_BITS(FRAC_BITS)) u_top (
        .clk(clk), .rst_n(rst_n), .sigma(sigma), .req_valid(req_valid),
        .req_ready(req_ready), .sample(sample), .uniform(uniform),
        .seed_out(seed_out), .status(status), .res_valid(res_valid),
        .res_ready(res_ready), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // log2 in Q28 of a value in 1 .. 2^31-1
    function automatic logic [63:0] log2_fixed(input logic [63:0] a);
        int          msb;
        logic [63:0] mant;
        logic [63:0] frac;
        msb  = 0;
        frac = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (a[i])
            begin
                msb = i;
            end
        end
        mant = a << (31 - msb);
        for (int i = 0; i < 28; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                mant    = mant >> 1;
            end
        end
        return (64'(msb) << 28) | frac;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= a)
            begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] q24_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'd8388608) >> 24;
    endfunction

    // advances the generator copy and forms the expected beat
    function automatic draw_t next_draw(input logic [15:0] sg);
        draw_t       d;
        logic [63:0] v, pv, lg, t2, t, tt, ttt, num, den, r, mag;
        bit          stuck, lower, neg;
        v      = 64'(gen_state);
        stuck  = (gen_state == 31'd0) || (gen_state == gng_pkg::GEN_MOD);
        d.sample = '0;
        d.fixed  = 1'b0;
        if (sg != 16'd0)
        begin
            v         = (v * 64'd16807) % 64'(gng_pkg::GEN_MOD);
            gen_state = 31'(v);
            if (!stuck)
            begin
                lower = v < (64'(gng_pkg::GEN_MOD) - v);
                pv    = lower ? v : 64'(gng_pkg::GEN_MOD) - v;
                lg    = log2_fixed(64'(gng_pkg::GEN_MOD)) - log2_fixed(pv);
                t2    = (lg * 64'(gng_pkg::LN2Q30) + (64'd1 << 24)) >> 25;
                t     = root_floor(t2 << 16);
                tt    = q24_mul(t, t);
                ttt   = q24_mul(tt, t);
                num   = 64'(gng_pkg::C0) + q24_mul(64'(gng_pkg::C1), t)
                        + q24_mul(64'(gng_pkg::C2), tt);
                den   = 64'(gng_pkg::ONE24) + q24_mul(64'(gng_pkg::D1), t)
                        + q24_mul(64'(gng_pkg::D2), tt) + q24_mul(64'(gng_pkg::D3), ttt);
                r     = ((num << 24) + (den >> 1)) / den;
                if (t >= r)
                begin
                    mag = t - r;
                    neg = lower;
                end
                else
                begin
                    mag = r - t;
                    neg = !lower;
                end
                mag = (64'(sg) * mag + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
                if (neg)
                begin
                    if (mag > 64'd8388608)
                    begin
                        mag = 64'd8388608;
                    end
                    d.sample = 24'(64'd0 - mag);
                end
                else
                begin
                    if (mag > 64'd8388607)
                    begin
                        mag = 64'd8388607;
                    end
                    d.sample = 24'(mag);
                end
            end
        end
        d.uniform  = 31'(v);
        d.seed_out = 31'(v) ^ gng_pkg::SEED_MASK;
        d.status   = stuck;
        return d;
    endfunction

    // seed write over the register port, only with nothing in flight
    task automatic write_seed(input logic [30:0] seed);
        @(posedge clk);
        wait (pending_draws.size() == 0);
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'd0;
        pwdata  <= {1'b0, seed};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
    endtask

    // offer one request beat and hold it until taken
    task automatic send_draw(input logic [15:0] sg);
        req_valid <= 1'b1;
        sigma     <= sg;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // monitor: track reset and seed writes, predict on accepted requests, check results
    always @(posedge clk)
    begin
        draw_t want;
        if (!rst_n)
        begin
            gen_state = 31'd1 ^ gng_pkg::SEED_MASK;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            gen_state = pwdata[30:0] ^ gng_pkg::SEED_MASK;
        end
        if (rst_n && req_valid && req_ready)
        begin
            want            = next_draw(sigma);
            want.fixed      = fix_pending;
            want.fix_sample = fix_sample_next;
            want.fix_status = fix_status_next;
            pending_draws.push_back(want);
        end
        if (rst_n && res_valid && res_ready)
        begin
            beats_out++;
            if (pending_draws.size() == 0)
            begin
                $error("result beat with nothing pending");
                fail_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (sample !== want.sample)
                begin
                    $error("sample: expected %0d actual %0d", want.sample, sample);
                    fail_count++;
                end
                if (uniform !== want.uniform)
                begin
                    $error("uniform: expected %0d actual %0d", want.uniform, uniform);
                    fail_count++;
                end
                if (seed_out !== want.seed_out)
                begin
                    $error("seed_out: expected %0d actual %0d", want.seed_out, seed_out);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, status);
                    fail_count++;
                end
                if (want.fixed && (sample !== want.fix_sample || status !== want.fix_status))
                begin
                    $error("sample/status: expected %0d/%0d actual %0d/%0d",
                           want.fix_sample, want.fix_status, sample, status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on stretches with no beat moving on either channel and no register access
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gaussian_noise_generator regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off partway through
    initial
    begin
        res_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_long && beats_out >= 300)
            begin
                // long back-pressure so the request side fills and stalls
                res_ready <= 1'b0;
                held_long = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 6) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        row_t rows[$];
        row_t r;
        logic [30:0] seed;
        rst_n        = 1'b0;
        sigma        = '0;
        req_valid    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idling_on    = 1'b1;
        fix_pending  = 1'b0;
        fix_sample_next = '0;
        fix_status_next = 1'b0;

        // directed table; hand-typed values only where obvious
        rows = '{
            '{ROW_DRAW, 31'd0,      1, 24'sd0, 1'b0},   // zero sigma after reset
            '{ROW_DRAW, 31'hFFFF,   0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'd1,      0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'h0100,   0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'h8000,   0, 24'sd0, 1'b0},
            '{ROW_SEED, 31'd1,      0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'hFFFF,   0, 24'sd0, 1'b0},   // full-scale sigma
            '{ROW_SEED, gng_pkg::SEED_MASK, 0, 24'sd0, 1'b0},   // generator value of zero
            '{ROW_DRAW, 31'd5,      1, 24'sd0, 1'b1},
            '{ROW_DRAW, 31'd0,      1, 24'sd0, 1'b1},
            '{ROW_DRAW, 31'hFFFF,   1, 24'sd0, 1'b1},
            '{ROW_SEED, gng_pkg::GEN_MOD ^ gng_pkg::SEED_MASK, 0, 24'sd0, 1'b0}, // all ones
            '{ROW_DRAW, 31'd0,      1, 24'sd0, 1'b1},
            '{ROW_DRAW, 31'd7,      1, 24'sd0, 1'b1},
            '{ROW_DRAW, 31'd7,      1, 24'sd0, 1'b1},
            '{ROW_SEED, 31'd0,      0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'h5555,   0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'hAAAA,   0, 24'sd0, 1'b0},
            '{ROW_SEED, gng_pkg::GEN_MOD, 0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'hFFFF,   0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'd0,      0, 24'sd0, 1'b0},
            '{ROW_DRAW, 31'h0001,   0, 24'sd0, 1'b0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.kind == ROW_SEED)
            begin
                req_valid <= 1'b0;
                write_seed(r.value);
            end
            else
            begin
                fix_pending     <= r.fixed;
                fix_sample_next <= r.fix_sample;
                fix_status_next <= r.fix_status;
                send_draw(16'(r.value));
            end
        end
        fix_pending <= 1'b0;

        // random part: phases of draws between seed writes
        for (int n = 0; n < 800; n++)
        begin
            if (n % 100 == 50)
            begin
                req_valid <= 1'b0;
                case ($urandom_range(0, 3))
                    0:       seed = 31'd0;
                    1:       seed = gng_pkg::GEN_MOD;
                    default: seed = 31'($urandom);
                endcase
                write_seed(seed);
            end
            if (n == 700)
            begin
                idling_on = 1'b0;   // closing stretch back to back
            end
            case ($urandom_range(0, 9))
                0:       send_draw(16'd0);
                1:       send_draw(16'hFFFF);
                2:       send_draw(16'($urandom_range(1, 255)));
                default: send_draw(16'($urandom));
            endcase
        end
        req_valid <= 1'b0;

        @(posedge clk);
        wait (pending_draws.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("gaussian_noise_generator regression: pass");
        end
        else
        begin
            $display("gaussian_noise_generator regression: fail");
        end
        $finish;
    end

endmodule
